// ----- sv/tgc_pkg.sv -----
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared constants for the turtle graphics canvas engine: field widths,
// command codes and heading codes.
// ----------------------------------------------------------------------------
package tgc_pkg;

   localparam int GRID_DEFAULT = 32;

   // word fields
   localparam int CMD_W       = 3;
   localparam int DIST_W      = 8;
   localparam int ROW_IDX_W   = 5;
   localparam int CELLS_W     = 32;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   // commands
   localparam logic [CMD_W-1:0] CMD_PEN_UP   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MOVE     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd5;

   // headings, clockwise
   localparam logic [1:0] HEAD_RIGHT = 2'd0;
   localparam logic [1:0] HEAD_DOWN  = 2'd1;
   localparam logic [1:0] HEAD_LEFT  = 2'd2;
   localparam logic [1:0] HEAD_UP    = 2'd3;

endpackage

// ----- sv/turtle_graphics_canvas_engine.sv -----
// Pen and turn commands finish without leaving idle; a horizontal move with the pen down
// does one read-modify-write of a single row, read in idle and written in ST_HWR; a
// vertical move with the pen down walks one canvas row per cycle, writing each row while
// reading the next. A dump moves each row through the read register into the output
// register, one row per cycle while rsp_tready is high. req_tready is low while a command
// is busy. Reset: position 0,0, heading right, pen up, all row-valid flags cleared.
// ----------------------------------------------------------------------------
// turtle_graphics_canvas_engine
// Turtle graphics engine over a GRID x GRID one-bit canvas held in a
// synchronous memory, with row dumps on a streaming output.
// ----------------------------------------------------------------------------
module turtle_graphics_canvas_engine
   import tgc_pkg::*;
#(
   parameter int GRID = GRID_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [2:0] command, [10:3] distance, rest zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [4:0] row_index, [36:5] row_cells, rest zero
   output logic                   rsp_tlast
);

   localparam int PosW      = (GRID > 1) ? $clog2(GRID) : 1;
   localparam int IdxWideW  = (PosW > ROW_IDX_W) ? PosW : ROW_IDX_W;
   localparam int CellWideW = (GRID > CELLS_W) ? GRID : CELLS_W;
   localparam logic [PosW-1:0] LastPos = PosW'(GRID - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HWR  = 4'b0010,
      ST_VWR  = 4'b0100,
      ST_DUMP = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [PosW-1:0]   pos_row_ff, pos_row_in;
   logic [PosW-1:0]   pos_col_ff, pos_col_in;
   logic [1:0]        heading_ff, heading_in;
   logic              pen_ff, pen_in;
   logic [PosW-1:0]   walk_ff, walk_in;   // row being walked or dumped
   logic [PosW-1:0]   cnt_ff, cnt_in;
   logic [PosW-1:0]   lo_ff, lo_in;
   logic [PosW-1:0]   hi_ff, hi_in;

   logic [GRID-1:0]   canvas_ff [GRID];
   logic [GRID-1:0]   valid_ff;
   logic [GRID-1:0]   rd_data_ff;
   logic              rd_vld_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [CELLS_W-1:0]   rsp_cells_ff, rsp_cells_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CMD_W-1:0]  cmd;
   logic [DIST_W-1:0] distance;
   logic              accept;
   logic [PosW-1:0]   room;
   logic [PosW-1:0]   steps;
   logic              rd_en;
   logic [PosW-1:0]   rd_addr;
   logic              wr_en;
   logic [PosW-1:0]   wr_addr;
   logic [GRID-1:0]   wr_data;
   logic [GRID-1:0]   old_row;
   logic [GRID-1:0]   hmask;
   logic [GRID-1:0]   col_bit;
   logic              slot_free;
   logic              load;
   logic [IdxWideW-1:0]  idx_wide;
   logic [CellWideW-1:0] cells_wide;

   assign cmd       = req_tdata[CMD_W-1:0];
   assign distance  = req_tdata[CMD_W +: DIST_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign old_row   = rd_vld_ff ? rd_data_ff : '0;
   assign col_bit   = GRID'(1) << pos_col_ff;

   always_comb begin
      case (heading_ff)
         HEAD_RIGHT: room = LastPos - pos_col_ff;
         HEAD_DOWN:  room = LastPos - pos_row_ff;
         HEAD_LEFT:  room = pos_col_ff;
         default:    room = pos_row_ff;
      endcase
      steps = (distance < DIST_W'(room)) ? PosW'(distance) : room;
   end

   always_comb begin
      for (int c = 0; c < GRID; c++) begin
         hmask[c] = (PosW'(c) >= lo_ff) && (PosW'(c) <= hi_ff);
      end
   end

   always_comb begin
      state_in   = state_ff;
      pos_row_in = pos_row_ff;
      pos_col_in = pos_col_ff;
      heading_in = heading_ff;
      pen_in     = pen_ff;
      walk_in    = walk_ff;
      cnt_in     = cnt_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      rd_en      = 1'b0;
      rd_addr    = walk_ff;
      wr_en      = 1'b0;
      wr_addr    = walk_ff;
      wr_data    = old_row | col_bit;
      load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_PEN_UP:   pen_in = 1'b0;
                  CMD_PEN_DOWN: pen_in = 1'b1;
                  CMD_RIGHT:    heading_in = heading_ff + 2'd1;
                  CMD_LEFT:     heading_in = heading_ff - 2'd1;
                  CMD_MOVE: begin
                     case (heading_ff)
                        HEAD_RIGHT: begin
                           pos_col_in = pos_col_ff + steps;
                           lo_in      = pos_col_ff + PosW'(1);
                           hi_in      = pos_col_ff + steps;
                        end
                        HEAD_LEFT: begin
                           pos_col_in = pos_col_ff - steps;
                           lo_in      = pos_col_ff - steps;
                           hi_in      = pos_col_ff - PosW'(1);
                        end
                        HEAD_DOWN: begin
                           pos_row_in = pos_row_ff + steps;
                           walk_in    = pos_row_ff + PosW'(1);
                        end
                        default: begin
                           pos_row_in = pos_row_ff - steps;
                           walk_in    = pos_row_ff - PosW'(1);
                        end
                     endcase
                     cnt_in = steps;
                     if (pen_ff && (steps != '0)) begin
                        rd_en = 1'b1;
                        if (heading_ff == HEAD_RIGHT || heading_ff == HEAD_LEFT) begin
                           rd_addr  = pos_row_ff;
                           state_in = ST_HWR;
                        end else begin
                           rd_addr  = walk_in;
                           state_in = ST_VWR;
                        end
                     end
                  end
                  CMD_DUMP: begin
                     walk_in  = '0;
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_DUMP;
                  end
                  default: ;
               endcase
            end
         end
         ST_HWR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_row_ff;
            wr_data  = old_row | hmask;
            state_in = ST_IDLE;
         end
         ST_VWR: begin
            // write this row while reading the next; rows differ, so no hazard
            wr_en = 1'b1;
            if (cnt_ff == PosW'(1)) begin
               state_in = ST_IDLE;
            end else begin
               walk_in = (heading_ff == HEAD_DOWN) ? walk_ff + PosW'(1)
                                                   : walk_ff - PosW'(1);
               cnt_in  = cnt_ff - PosW'(1);
               rd_en   = 1'b1;
               rd_addr = walk_in;
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               load = 1'b1;
               if (walk_ff == LastPos) begin
                  state_in = ST_IDLE;
               end else begin
                  walk_in = walk_ff + PosW'(1);
                  rd_en   = 1'b1;
                  rd_addr = walk_in;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_wide               = '0;
      idx_wide[PosW-1:0]     = walk_ff;
      cells_wide             = '0;
      cells_wide[GRID-1:0]   = old_row;
      rsp_idx_in   = load ? idx_wide[ROW_IDX_W-1:0] : rsp_idx_ff;
      rsp_cells_in = load ? cells_wide[CELLS_W-1:0] : rsp_cells_ff;
      rsp_last_in  = load ? (walk_ff == LastPos) : rsp_last_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_row_ff   <= '0;
         pos_col_ff   <= '0;
         heading_ff   <= HEAD_RIGHT;
         pen_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_row_ff   <= pos_row_in;
         pos_col_ff   <= pos_col_in;
         heading_ff   <= heading_in;
         pen_ff       <= pen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_ff      <= walk_in;
      cnt_ff       <= cnt_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // canvas memory, one row per entry, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         canvas_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= canvas_ff[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      rsp_tdata                          = '0;
      rsp_tdata[ROW_IDX_W-1:0]           = rsp_idx_ff;
      rsp_tdata[ROW_IDX_W +: CELLS_W]    = rsp_cells_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- sv/tgc_checker.sv -----
// ----------------------------------------------------------------------------
// tgc_checker
// Port-level checks for the turtle graphics canvas engine, bound to the top.
// ----------------------------------------------------------------------------
module tgc_checker
   import tgc_pkg::*;
#(
   parameter int GRID = GRID_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   // no new command while a dump is still running
   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("command accepted during dump");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[ROW_IDX_W-1:0] == ROW_IDX_W'(GRID - 1))
      else $error("last word carries wrong row index");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         !rsp_tvalid ||
         rsp_tdata[ROW_IDX_W-1:0] == ROW_IDX_W'($past(rsp_tdata[ROW_IDX_W-1:0]) + 1))
      else $error("dump rows out of order");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind turtle_graphics_canvas_engine tgc_checker #(.GRID(GRID)) u_tgc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives turtle commands into the canvas engine and checks every dumped row
// against a cycle-free model of the turtle. A short table of commands comes
// first, then random commands, with idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import tgc_pkg::*;

   localparam int GRID = GRID_DEFAULT;

   // codes the block must ignore
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic [ROW_IDX_W-1:0] idx;
      logic [CELLS_W-1:0]   cells;
      logic                 last;
   } canvas_row_type;

   // one table entry; pinned entries carry a dump whose only drawn row is row 0
   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [DIST_W-1:0]  distance;
      bit                 pinned;
      logic [CELLS_W-1:0] row0;
   } plan_step_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [2:0] command, [10:3] distance
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [4:0] row_index, [36:5] row_cells
   logic                   rsp_tlast;

   // turtle state as seen by the checker
   logic [CELLS_W-1:0] drawn [GRID];
   int                 at_row;
   int                 at_col;
   logic [1:0]         facing;
   bit                 pen_is_down;

   canvas_row_type pending_rows [$];
   int             errors = 0;
   int             idle_phase = 0;
   bit             long_hold_req = 1'b0;

   plan_step_type plan [25];

   always #5 clock = ~clock;

   turtle_graphics_canvas_engine #(.GRID(GRID)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic int sender_idle_pct();
      return (idle_phase == 0) ? 33 : (idle_phase == 1) ? 59 : 0;
   endfunction

   function automatic int receiver_idle_pct();
      return (idle_phase == 0) ? 59 : (idle_phase == 1) ? 33 : 0;
   endfunction

   task automatic walk_turtle(input logic [DIST_W-1:0] distance);
      int room;
      int steps;
      case (facing)
         HEAD_RIGHT: room = GRID - 1 - at_col;
         HEAD_DOWN:  room = GRID - 1 - at_row;
         HEAD_LEFT:  room = at_col;
         default:    room = at_row;
      endcase
      steps = (int'(distance) < room) ? int'(distance) : room;
      for (int k = 0; k < steps; k++) begin
         case (facing)
            HEAD_RIGHT: at_col++;
            HEAD_DOWN:  at_row++;
            HEAD_LEFT:  at_col--;
            default:    at_row--;
         endcase
         // start cell is never marked, only cells entered
         if (pen_is_down)
            drawn[at_row][at_col] = 1'b1;
      end
   endtask

   task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                input logic [DIST_W-1:0] distance);
      canvas_row_type r;
      case (cmd)
         CMD_PEN_UP:   pen_is_down = 1'b0;
         CMD_PEN_DOWN: pen_is_down = 1'b1;
         CMD_RIGHT:    facing = facing + 2'd1;
         CMD_LEFT:     facing = facing + 2'd3;
         CMD_MOVE:     walk_turtle(distance);
         CMD_DUMP: begin
            for (int i = 0; i < GRID; i++) begin
               r.idx   = i[ROW_IDX_W-1:0];
               r.cells = drawn[i];
               r.last  = (i == GRID - 1);
               pending_rows.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic push_pinned_dump(input logic [CELLS_W-1:0] row0);
      canvas_row_type r;
      for (int i = 0; i < GRID; i++) begin
         r.idx   = i[ROW_IDX_W-1:0];
         r.cells = (i == 0) ? row0 : '0;
         r.last  = (i == GRID - 1);
         pending_rows.push_back(r);
      end
   endtask

   // offers one word and returns once it has been taken; tvalid stays high
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DIST_W-1:0] distance,
                            input bit pinned, input logic [CELLS_W-1:0] row0);
      // idle cycle by cycle at the sender's rate
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - CMD_W - DIST_W){1'b0}}, distance, cmd};
      do @(posedge clock); while (!req_tready);
      if (pinned)
         push_pinned_dump(row0);
      else
         apply_command(cmd, distance);
   endtask

   task automatic drain_rows();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_rows.size() != 0);
   endtask

   // receiver: random back-pressure plus one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      canvas_row_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rows.size() == 0) begin
            $error("unexpected row word: row_index %0d", rsp_tdata[4:0]);
            errors++;
         end else begin
            want = pending_rows.pop_front();
            if (rsp_tdata[4:0] !== want.idx) begin
               $error("row_index: expected %0d, got %0d", want.idx, rsp_tdata[4:0]);
               errors++;
            end
            if (rsp_tdata[36:5] !== want.cells) begin
               $error("row_cells (row %0d): expected %h, got %h",
                      want.idx, want.cells, rsp_tdata[36:5]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_row (row %0d): expected %b, got %b",
                      want.idx, want.last, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[RSP_TDATA_W-1:37] !== '0) begin
               $error("tdata padding: expected 0, got %h", rsp_tdata[RSP_TDATA_W-1:37]);
               errors++;
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("turtle_graphics_canvas_engine test failed");
      $finish;
   end

   initial begin
      logic [CMD_W-1:0]  cmd;
      logic [DIST_W-1:0] distance;
      int                pick;

      for (int i = 0; i < GRID; i++)
         drawn[i] = '0;
      at_row      = 0;
      at_col      = 0;
      facing      = HEAD_RIGHT;
      pen_is_down = 1'b0;

      // walk: edges, clipping, ignored codes, then the boundary of the canvas
      plan = '{
         '{CMD_DUMP,     8'hFF, 1'b1, 32'h0},          // blank after reset
         '{CMD_PEN_DOWN, 8'hFF, 1'b0, 32'h0},
         '{CMD_MOVE,     8'h00, 1'b0, 32'h0},          // zero move
         '{CMD_LEFT,     8'h00, 1'b0, 32'h0},
         '{CMD_MOVE,     8'h09, 1'b0, 32'h0},          // facing up from row 0
         '{CMD_RIGHT,    8'h00, 1'b0, 32'h0},
         '{CMD_SPARE_6,  8'hAA, 1'b0, 32'h0},
         '{CMD_SPARE_7,  8'h55, 1'b0, 32'h0},
         '{CMD_DUMP,     8'h00, 1'b1, 32'h0},          // still blank
         '{CMD_MOVE,     8'hFF, 1'b0, 32'h0},          // clips at column 31
         '{CMD_DUMP,     8'h00, 1'b1, 32'hFFFF_FFFE},  // start cell untouched
         '{CMD_RIGHT,    8'h00, 1'b0, 32'h0},
         '{CMD_MOVE,     8'hFF, 1'b0, 32'h0},
         '{CMD_RIGHT,    8'h00, 1'b0, 32'h0},
         '{CMD_PEN_UP,   8'h00, 1'b0, 32'h0},
         '{CMD_MOVE,     8'h03, 1'b0, 32'h0},
         '{CMD_PEN_DOWN, 8'h00, 1'b0, 32'h0},
         '{CMD_MOVE,     8'hFF, 1'b0, 32'h0},
         '{CMD_RIGHT,    8'h00, 1'b0, 32'h0},
         '{CMD_MOVE,     8'h05, 1'b0, 32'h0},
         '{CMD_MOVE,     8'h80, 1'b0, 32'h0},
         '{CMD_PEN_UP,   8'h00, 1'b0, 32'h0},
         '{CMD_LEFT,     8'h00, 1'b0, 32'h0},
         '{CMD_MOVE,     8'h07, 1'b0, 32'h0},          // left edge, pen up
         '{CMD_DUMP,     8'h00, 1'b0, 32'h0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_word(plan[i].cmd, plan[i].distance, plan[i].pinned, plan[i].row0);

      for (int n = 0; n < 200; n++) begin
         idle_phase = (n < 70) ? 0 : (n < 140) ? 1 : 2;
         if (n == 120)
            drain_rows();
         pick = $urandom_range(0, 99);
         if (pick < 12)      cmd = CMD_PEN_UP;
         else if (pick < 30) cmd = CMD_PEN_DOWN;
         else if (pick < 42) cmd = CMD_RIGHT;
         else if (pick < 54) cmd = CMD_LEFT;
         else if (pick < 82) cmd = CMD_MOVE;
         else if (pick < 94) cmd = CMD_DUMP;
         else                cmd = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;
         // long receiver hold lands on a dump so the engine backs up
         if (n == 40) begin
            cmd = CMD_DUMP;
            long_hold_req = 1'b1;
         end
         distance = ($urandom_range(0, 99) < 15) ? DIST_W'($urandom_range(0, 255))
                                                 : DIST_W'($urandom_range(0, 12));
         send_word(cmd, distance, 1'b0, '0);
      end

      drain_rows();
      repeat (GRID + 8) @(posedge clock);
      if (errors == 0)
         $display("turtle_graphics_canvas_engine test passed");
      else
         $display("turtle_graphics_canvas_engine test failed");
      $finish;
   end

endmodule

// ----- files.f -----
sv/tgc_pkg.sv
sv/turtle_graphics_canvas_engine.sv
sv/tgc_checker.sv
dv/tb_top.sv
